>>> hw/rtl/acpa_pkg.sv
package acpa_pkg;

  localparam int unsigned ModelW = 3;
  localparam int unsigned LeakW  = 4;

  typedef enum logic [ModelW-1:0] {
    MODEL_R0R1_HD   = 3'd0,
    MODEL_R0_ADDKEY = 3'd1,
    MODEL_R0_SBOX   = 3'd2,
    MODEL_R9_MIXCOL = 3'd3,
    MODEL_R10_HD    = 3'd4,
    MODEL_R10_SBIN  = 3'd5
  } model_t;

  localparam logic [ModelW-1:0] ModelReset = MODEL_R0_SBOX;

  // operands handed from the byte select stage to the sbox/count stage
  typedef struct packed {
    logic [ModelW-1:0] model;
    logic [7:0]        sbox_in;
    logic [7:0]        mix;
  } hyp_ops_t;

  localparam logic [7:0] FwdBox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] InvBox [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [3:0] RowShift [16] = '{
    4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
    4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11
  };

  localparam logic [3:0] RowUnshift [16] = '{
    4'd0, 4'd13, 4'd10, 4'd7, 4'd4, 4'd1, 4'd14, 4'd11,
    4'd8, 4'd5, 4'd2, 4'd15, 4'd12, 4'd9, 4'd6, 4'd3
  };

endpackage

>>> hw/rtl/acpa_select.sv
// Byte selection: picks the state bytes and guess mask per leakage model.
module acpa_select (
  input  logic [2:0]        model,
  input  logic [63:0]       plaintext_low,
  input  logic [63:0]       plaintext_high,
  input  logic [63:0]       ciphertext_low,
  input  logic [63:0]       ciphertext_high,
  input  logic [3:0]        byte_position,
  input  logic [7:0]        key_hyp,
  input  logic [7:0]        second_guess,
  output acpa_pkg::hyp_ops_t ops
);
  import acpa_pkg::*;

  logic [7:0] pt [16];
  logic [7:0] ct [16];
  logic [3:0] pos_sr;
  logic [3:0] pos_isr;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pt[i]   = plaintext_low[8*i +: 8];
      pt[i+8] = plaintext_high[8*i +: 8];
      ct[i]   = ciphertext_low[8*i +: 8];
      ct[i+8] = ciphertext_high[8*i +: 8];
    end
  end

  assign pos_sr  = RowShift[byte_position];
  assign pos_isr = RowUnshift[byte_position];

  always_comb begin
    ops.model   = model;
    ops.sbox_in = '0;
    ops.mix     = '0;
    case (model)
      MODEL_R0R1_HD: begin
        ops.sbox_in = pt[byte_position] ^ key_hyp;
        ops.mix     = pt[pos_isr];
      end
      MODEL_R0_ADDKEY, MODEL_R0_SBOX: begin
        ops.sbox_in = pt[byte_position] ^ key_hyp;
      end
      MODEL_R9_MIXCOL: begin
        ops.sbox_in = ct[pos_isr] ^ key_hyp;
        ops.mix     = second_guess;
      end
      MODEL_R10_HD: begin
        ops.sbox_in = ct[byte_position] ^ key_hyp;
        ops.mix     = ct[pos_sr];
      end
      MODEL_R10_SBIN: begin
        ops.sbox_in = ct[pos_isr] ^ key_hyp;
      end
      default: begin
        ops.sbox_in = '0;
      end
    endcase
  end

endmodule

>>> hw/rtl/acpa_weigh.sv
// S-box lookup, distance mix and popcount.
module acpa_weigh #(
  parameter int unsigned LEAK_W = acpa_pkg::LeakW
) (
  input  acpa_pkg::hyp_ops_t ops,
  output logic [LEAK_W-1:0]  leakage
);
  import acpa_pkg::*;

  logic [7:0] sub;
  logic [7:0] val;
  logic       zero;

  always_comb begin
    sub  = ops.sbox_in;
    zero = 1'b0;
    case (ops.model)
      MODEL_R0R1_HD, MODEL_R0_SBOX:                  sub = FwdBox[ops.sbox_in];
      MODEL_R9_MIXCOL, MODEL_R10_HD, MODEL_R10_SBIN: sub = InvBox[ops.sbox_in];
      MODEL_R0_ADDKEY:                               sub = ops.sbox_in;
      default:                                       zero = 1'b1;
    endcase
    val = zero ? 8'h00 : (sub ^ ops.mix);
  end

  always_comb begin
    leakage = '0;
    for (int i = 0; i < 8; i++) begin
      leakage = leakage + LEAK_W'(val[i]);
    end
  end

endmodule

>>> hw/rtl/aes_cpa_leakage_hypothesis_top.sv
// AES-128 CPA leakage hypothesis.
// Input channel: in_valid / in_stall with plaintext, ciphertext, byte
// position and one or two key guesses. A transaction occurs at a rising edge
// with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with leakage (0..8), the Hamming
// weight or distance of the intermediate byte picked by the model select.
// Config: cfg_we / cfg_wdata write the model select; write only while idle.
// Path: the input transaction loads the input register, and out_valid
// rises once the result register takes its operand, which a stall on the
// output can hold off.
// Throughput: one transaction per cycle while out_stall is low; the input
// and result registers form a two-stage pipeline, each stage refilled as
// soon as the one after it moves on.
// When out_stall is high with a result waiting, the result register holds
// and the input register fills; in_stall rises only when both are full.
// Reset (rst, synchronous, active high) empties both stages and sets
// the model select to 2 (round 0 S-box output).
module aes_cpa_leakage_hypothesis_top #(
  parameter int unsigned LEAK_W = acpa_pkg::LeakW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [63:0]       plaintext_low,
  input  logic [63:0]       plaintext_high,
  input  logic [63:0]       ciphertext_low,
  input  logic [63:0]       ciphertext_high,
  input  logic [3:0]        byte_position,
  input  logic [7:0]        key_hyp,
  input  logic [7:0]        second_guess,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LEAK_W-1:0] leakage
);
  import acpa_pkg::*;

  logic [ModelW-1:0] model;
  hyp_ops_t          ops_next;
  hyp_ops_t          ops;
  logic              ops_valid;
  logic [LEAK_W-1:0] leak_next;
  logic              res_adv;
  logic              ops_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      model <= ModelReset;
    end else if (cfg_we) begin
      model <= cfg_wdata;
    end
  end

  // result register moves when empty or being taken
  assign res_adv  = ops_valid && (!out_valid || !out_stall);
  assign ops_adv  = !ops_valid || res_adv;
  assign in_stall = !ops_adv;

  // stage 1: byte selection into the operand register
  acpa_select u_select (
    .model          (model),
    .plaintext_low  (plaintext_low),
    .plaintext_high (plaintext_high),
    .ciphertext_low (ciphertext_low),
    .ciphertext_high(ciphertext_high),
    .byte_position  (byte_position),
    .key_hyp        (key_hyp),
    .second_guess   (second_guess),
    .ops            (ops_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ops_valid <= 1'b0;
    end else if (ops_adv) begin
      ops_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ops_adv && in_valid) begin
      ops <= ops_next;
    end
  end

  // stage 2: sbox, mix and popcount into the result register
  acpa_weigh #(
    .LEAK_W(LEAK_W)
  ) u_weigh (
    .ops    (ops),
    .leakage(leak_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= ops_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_adv) begin
      leakage <= leak_next;
    end
  end

endmodule

>>> hw/rtl/acpa_checker.sv
module acpa_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] leakage
);

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(leakage))
    else $error("stalled result changed");

  // results never exceed eight
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> leakage <= 4'd8)
    else $error("leakage out of range");

  // input only stalls when the output is backed up
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without back pressure");

  // an accepted transaction shows up as a valid result when the output does not stall
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_stall ##1 !out_stall |=> out_valid)
    else $error("result missing");

endmodule

bind aes_cpa_leakage_hypothesis_top acpa_checker u_acpa_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .leakage  (leakage)
);

>>> verif/leakage_checker.sv
module leakage_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] plaintext_low,
  input  logic [63:0] plaintext_high,
  input  logic [63:0] ciphertext_low,
  input  logic [63:0] ciphertext_high,
  input  logic [3:0]  byte_position,
  input  logic [7:0]  key_hyp,
  input  logic [7:0]  second_guess,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  leakage,
  output int          fail_count,
  output int          pending
);
  import acpa_pkg::*;

  // own copies of the cipher tables (the package arrays are data, not logic)
  logic [7:0] sbox_tab [256];
  logic [7:0] isbox_tab [256];
  logic [3:0] shift_tab [16];
  logic [3:0] unshift_tab [16];
  logic [2:0] model_sel;
  logic [3:0] hyp_q[$];

  initial begin
    sbox_tab = FwdBox;
    isbox_tab = InvBox;
    shift_tab = RowShift;
    unshift_tab = RowUnshift;
  end

  assign pending = hyp_q.size();

  function automatic logic [7:0] byte_of(logic [63:0] lo, logic [63:0] hi, logic [3:0] pos);
    logic [63:0] half;
    half = pos[3] ? hi : lo;
    return half[8*pos[2:0] +: 8];
  endfunction

  function automatic logic [3:0] weight(logic [7:0] v);
    logic [3:0] n;
    n = 0;
    for (int i = 0; i < 8; i++) n += v[i];
    return n;
  endfunction

  function automatic logic [3:0] hypothesis(logic [2:0] m, logic [63:0] pl, logic [63:0] ph,
                                            logic [63:0] cl, logic [63:0] ch, logic [3:0] b,
                                            logic [7:0] k, logic [7:0] k2);
    case (m)
      MODEL_R0R1_HD:
        return weight(sbox_tab[byte_of(pl, ph, b) ^ k] ^ byte_of(pl, ph, unshift_tab[b]));
      MODEL_R0_ADDKEY: return weight(byte_of(pl, ph, b) ^ k);
      MODEL_R0_SBOX:   return weight(sbox_tab[byte_of(pl, ph, b) ^ k]);
      MODEL_R9_MIXCOL: return weight(isbox_tab[byte_of(cl, ch, unshift_tab[b]) ^ k] ^ k2);
      MODEL_R10_HD:
        return weight(isbox_tab[byte_of(cl, ch, b) ^ k] ^ byte_of(cl, ch, shift_tab[b]));
      MODEL_R10_SBIN:  return weight(isbox_tab[byte_of(cl, ch, unshift_tab[b]) ^ k]);
      default:         return 4'd0;
    endcase
  endfunction

  always @(posedge clk) begin
    logic [3:0] exp_val;
    if (rst) begin
      model_sel <= ModelReset;
      hyp_q.delete();
    end else begin
      if (cfg_we) model_sel <= cfg_wdata;
      if (in_valid && !in_stall)
        hyp_q.push_back(hypothesis(model_sel, plaintext_low, plaintext_high, ciphertext_low,
                                   ciphertext_high, byte_position, key_hyp, second_guess));
      if (out_valid && !out_stall) begin
        if (hyp_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual leakage %0d",
                   $time, leakage);
          fail_count++;
        end else begin
          exp_val = hyp_q.pop_front();
          if (leakage !== exp_val) begin
            $display("%0t: leakage mismatch, expected %0d, actual %0d", $time, exp_val, leakage);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

>>> verif/tb_aes_cpa_leakage_hypothesis_top.sv
module tb_aes_cpa_leakage_hypothesis_top;
  import acpa_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] plaintext_low, plaintext_high, ciphertext_low, ciphertext_high;
  logic [3:0]  byte_position;
  logic [7:0]  key_hyp, second_guess;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  leakage;
  int          fail_count;
  int          pending;
  // idle rates in percent for sender and receiver
  int          send_idle, recv_idle;

  aes_cpa_leakage_hypothesis_top dut (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_stall,
    .plaintext_low, .plaintext_high, .ciphertext_low, .ciphertext_high,
    .byte_position, .key_hyp, .second_guess, .out_valid, .out_stall, .leakage
  );

  leakage_checker chk (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_stall,
    .plaintext_low, .plaintext_high, .ciphertext_low, .ciphertext_high,
    .byte_position, .key_hyp, .second_guess, .out_valid, .out_stall, .leakage,
    .fail_count, .pending
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Receiver side: out_stall re-rolled each edge from the current idle rate.
  always @(posedge clk) begin
    out_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // One input transaction; valid stays high back to back when no gap is drawn.
  task automatic send(logic [63:0] pl, logic [63:0] ph, logic [63:0] cl, logic [63:0] ch,
                      logic [3:0] b, logic [7:0] k, logic [7:0] k2);
    while ((send_idle > 0) && ($urandom_range(99) < send_idle)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    plaintext_low   <= pl;
    plaintext_high  <= ph;
    ciphertext_low  <= cl;
    ciphertext_high <= ch;
    byte_position   <= b;
    key_hyp         <= k;
    second_guess    <= k2;
    do @(posedge clk); while (in_stall);
  endtask

  // Random transaction; byte patterns biased toward all-zero / all-one halves
  task automatic send_random();
    logic [63:0] f [4];
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(9))
        0:       f[i] = '0;
        1:       f[i] = '1;
        default: f[i] = rand64();
      endcase
    end
    send(f[0], f[1], f[2], f[3], 4'($urandom_range(15)), 8'($urandom_range(255)),
         8'($urandom_range(255)));
  endtask

  // Register write only with the pipeline drained; the wait covers latency.
  task automatic set_model(logic [2:0] m);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst = 1; cfg_we = 0; cfg_wdata = '0; in_valid = 0;
    plaintext_low = '0; plaintext_high = '0; ciphertext_low = '0; ciphertext_high = '0;
    byte_position = '0; key_hyp = '0; second_guess = '0;
    send_idle = 0; recv_idle = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset model (round 0 S-box), extremes of fields.
    send('0, '0, '0, '0, 4'd0, 8'h00, 8'h00);
    send('1, '1, '1, '1, 4'd15, 8'hff, 8'hff);
    // Every model including the unused selectors 6 and 7, each with the
    // extremes and two byte positions (an odd one and 8).
    for (int m = 0; m < 8; m++) begin
      set_model(3'(m));
      send(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'hf7f6f5f4f3f2f1f0,
           64'hfffefdfcfbfaf9f8, 4'(m * 2 + 1), 8'h5a, 8'ha5);
      send('1, '0, '0, '1, 4'd8, 8'hff, 8'h00);
      // second guess changed alone: only the round 9 model may react
      send('1, '0, '0, '1, 4'd8, 8'hff, 8'hff);
    end

    // Random phases: settings 0 to 6 plus a random one, three idling regimes.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 14; recv_idle = 51; end
        1: begin send_idle = 51; recv_idle = 14; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int m = 0; m < 8; m++) begin
        set_model((m == 7) ? 3'($urandom_range(7)) : 3'(m));
        // mostly the six real models; the unused ones get short bursts
        for (int n = 0; n < ((m < 6) ? 85 : 30); n++) send_random();
      end
    end

    in_valid <= 1'b0;
    send_idle = 0;
    recv_idle = 0;
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog; far above the slowest correct run.
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/acpa_pkg.sv
hw/rtl/acpa_select.sv
hw/rtl/acpa_weigh.sv
hw/rtl/aes_cpa_leakage_hypothesis_top.sv
hw/rtl/acpa_checker.sv
verif/leakage_checker.sv
verif/tb_aes_cpa_leakage_hypothesis_top.sv
